// File: rtl/wvsd_pkg.sv
// ----------------------------------------------------------------------------
// wvsd_pkg
// Shared widths, codes and interface types of the window variance
// stability detector.
// ----------------------------------------------------------------------------
package wvsd_pkg;

    localparam int WINDOW_SIZE_DEF = 12;

    localparam int MODE_W     = 2;
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 32;
    localparam int STATUS_W   = 3;
    localparam int MEAN_W     = 23;
    localparam int VAR_W      = 32;
    localparam int COUNT_W    = 8;
    localparam int TOL_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FAIL   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_COLLECTING = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STABLE     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNSTABLE   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TIMEOUT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_ERROR      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;

    localparam logic [TIME_W-1:0]  TIMEOUT_RST   = 32'd10000;
    localparam logic [TOL_W-1:0]   TOLERANCE_RST = 16'd1000;
    localparam logic [COUNT_W-1:0] COUNT_MAX     = 8'd255;

    // ns to us: floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38 for any 32-bit x
    localparam int          US_SHIFT = 38;
    localparam int          US_RECIP_W = 29;
    localparam logic [US_RECIP_W-1:0] US_RECIP = 29'd274877907;

    typedef struct packed {
        logic              clear;
        logic              push;
        logic              run;
        logic [MEAN_W-1:0] data;
    } t_stats_req;

    typedef struct packed {
        logic              done;
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
    } t_stats_rsp;

endpackage

// File: rtl/wvsd_stats.sv
// ----------------------------------------------------------------------------
// wvsd_stats
// Window ring memory with a mean pass and a variance pass over its entries.
// ----------------------------------------------------------------------------
module wvsd_stats #(
    parameter int WINDOW_SIZE = wvsd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wvsd_pkg::t_stats_req i_req,
    output wvsd_pkg::t_stats_rsp o_rsp
);

    localparam int IDX_W  = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W  = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W  = wvsd_pkg::MEAN_W + IDX_W;
    localparam int SH1    = SUM_W + IDX_W;
    localparam int SH2    = wvsd_pkg::VAR_W + IDX_W;
    localparam int RCP1_W = SUM_W + 1;
    localparam int RCP2_W = wvsd_pkg::VAR_W + 1;
    localparam logic [RCP1_W-1:0] RECIP1 =
        RCP1_W'(((64'd1 << SH1) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));
    localparam logic [RCP2_W-1:0] RECIP2 =
        RCP2_W'(((64'd1 << SH2) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

    typedef enum logic [2:0] {
        SS_IDLE,
        SS_SUM,
        SS_MEAN,
        SS_VAR,
        SS_VDIV
    } t_state;

    t_state                       r_state;
    logic [wvsd_pkg::MEAN_W-1:0]  r_mem [WINDOW_SIZE];
    logic [wvsd_pkg::MEAN_W-1:0]  r_rdata;
    logic [IDX_W-1:0]             r_widx;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_rd_vld;
    logic                         r_sq_vld;
    logic [SUM_W-1:0]             r_sum;
    logic [wvsd_pkg::MEAN_W-1:0]  r_mean;
    logic [wvsd_pkg::VAR_W-1:0]   r_sq;
    logic [wvsd_pkg::VAR_W-1:0]   r_vacc;
    logic [wvsd_pkg::VAR_W-1:0]   r_var;
    logic                         r_done;

    logic                         w_rd_en;
    logic [IDX_W-1:0]             n_widx;
    logic [wvsd_pkg::VAR_W-1:0]   w_diff;
    logic [wvsd_pkg::VAR_W-1:0]   w_sq;
    logic [SH1+wvsd_pkg::MEAN_W-1:0] w_mprod;
    logic [SH2+wvsd_pkg::VAR_W-1:0]  w_vprod;

    assign w_rd_en = ((r_state == SS_SUM) || (r_state == SS_VAR))
                     && (r_cnt < CNT_W'(WINDOW_SIZE));
    assign n_widx  = (r_widx == IDX_W'(WINDOW_SIZE - 1)) ? '0 : r_widx + 1'b1;
    assign w_diff  = wvsd_pkg::VAR_W'(r_rdata) - wvsd_pkg::VAR_W'(r_mean);
    assign w_sq    = w_diff * w_diff;
    assign w_mprod = r_sum * RECIP1;
    assign w_vprod = r_vacc * RECIP2;

    always_ff @(posedge i_clk) begin
        if (i_req.push) begin
            r_mem[r_widx] <= i_req.data;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_cnt[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= SS_IDLE;
            r_widx   <= '0;
            r_cnt    <= '0;
            r_rd_vld <= 1'b0;
            r_sq_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done   <= (r_state == SS_VDIV);
            r_rd_vld <= w_rd_en;
            r_sq_vld <= (r_state == SS_VAR) && r_rd_vld;
            if (i_req.clear) begin
                r_widx <= '0;
            end else if (i_req.push) begin
                r_widx <= n_widx;
            end
            case (r_state)
                SS_IDLE: begin
                    if (i_req.run) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= SS_SUM;
                    end
                end
                SS_SUM: begin
                    if (w_rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_sum <= r_sum + SUM_W'(r_rdata);
                    end
                    if (!w_rd_en && !r_rd_vld) begin
                        r_state <= SS_MEAN;
                    end
                end
                SS_MEAN: begin
                    r_mean  <= w_mprod[SH1 +: wvsd_pkg::MEAN_W];
                    r_cnt   <= '0;
                    r_vacc  <= '0;
                    r_state <= SS_VAR;
                end
                SS_VAR: begin
                    if (w_rd_en) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_rd_vld) begin
                        r_sq <= w_sq;
                    end
                    if (r_sq_vld) begin
                        r_vacc <= r_vacc + r_sq;
                    end
                    if (!w_rd_en && !r_rd_vld && !r_sq_vld) begin
                        r_state <= SS_VDIV;
                    end
                end
                SS_VDIV: begin
                    r_var   <= w_vprod[SH2 +: wvsd_pkg::VAR_W];
                    r_state <= SS_IDLE;
                end
                default: begin
                    r_state <= SS_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.mean     = r_mean;
    assign o_rsp.variance = r_var;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(WINDOW_SIZE))
        else $error("read counter beyond window");

    a_run_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.run |-> r_state == SS_IDLE)
        else $error("pass started while busy");

    a_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.push |-> r_state == SS_IDLE)
        else $error("ring written during a pass");

    a_sq_in_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_vld |-> r_state == SS_VAR)
        else $error("square stage valid outside variance pass");

endmodule

// File: rtl/window_variance_stability_detector_core.sv
// ----------------------------------------------------------------------------
// window_variance_stability_detector_core
// Qualifies conductivity readings as stable from the variance of a sliding
// window of the latest samples, with a run timeout and failure handling.
//
//   channel  direction  handshake                   payload
//   in       sink       i_in_valid / o_in_stall     i_mode, i_now_ms, i_sample_ns
//   out      source     o_out_valid / i_out_stall   o_status, o_mean_us,
//                                                   o_variance_out, o_samples_seen
//   cfg      sink       i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// start, ignored, timeout and failure items go from idle straight to the done
// state; a sample item passes through conversion and the ring write, and once
// the window is full also through a mean pass and a variance pass over the
// single read port of the ring memory. reset sets the config defaults and
// clears the run, the count and the output valid flag; ring entries are not
// cleared and are only read after being written in the current run.
// a waiting result sits in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module window_variance_stability_detector_core #(
    parameter int WINDOW_SIZE = wvsd_pkg::WINDOW_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [wvsd_pkg::MODE_W-1:0]       i_mode,
    input  logic [wvsd_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [wvsd_pkg::SAMPLE_W-1:0]     i_sample_ns,

    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [wvsd_pkg::STATUS_W-1:0]     o_status,
    output logic [wvsd_pkg::MEAN_W-1:0]       o_mean_us,
    output logic [wvsd_pkg::VAR_W-1:0]        o_variance_out,
    output logic [wvsd_pkg::COUNT_W-1:0]      o_samples_seen,

    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wvsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wvsd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_WRITE,
        S_STATS,
        S_DONE
    } t_state;

    t_state                            r_state;
    logic [wvsd_pkg::TIME_W-1:0]       r_timeout;
    logic [wvsd_pkg::TOL_W-1:0]        r_tol;
    logic [2*wvsd_pkg::TOL_W-1:0]      r_tol2;
    logic [wvsd_pkg::TIME_W-1:0]       r_start_time;
    logic [wvsd_pkg::COUNT_W-1:0]      r_total;
    logic                              r_active;
    logic [wvsd_pkg::SAMPLE_W-1:0]     r_sample;
    logic [wvsd_pkg::MEAN_W-1:0]       r_quot;
    logic [wvsd_pkg::STATUS_W-1:0]     r_res_status;
    logic [wvsd_pkg::MEAN_W-1:0]       r_res_mean;
    logic [wvsd_pkg::VAR_W-1:0]        r_res_var;
    logic                              r_out_valid;
    logic [wvsd_pkg::STATUS_W-1:0]     r_out_status;
    logic [wvsd_pkg::MEAN_W-1:0]       r_out_mean;
    logic [wvsd_pkg::VAR_W-1:0]        r_out_var;
    logic [wvsd_pkg::COUNT_W-1:0]      r_out_samples;

    logic                              w_in_take;
    logic                              w_out_take;
    logic                              w_expired;
    logic [wvsd_pkg::COUNT_W-1:0]      n_total;
    logic                              w_full;
    logic [wvsd_pkg::SAMPLE_W+wvsd_pkg::US_RECIP_W-1:0] w_uprod;
    wvsd_pkg::t_stats_req              w_req;
    wvsd_pkg::t_stats_rsp              w_rsp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_take   = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_expired   = (i_now_ms - r_start_time) > r_timeout;
    assign n_total     = (r_total == wvsd_pkg::COUNT_MAX) ? r_total : r_total + 1'b1;
    assign w_full      = n_total >= wvsd_pkg::COUNT_W'(WINDOW_SIZE);
    assign w_uprod     = r_sample * wvsd_pkg::US_RECIP;

    assign w_req.clear = w_in_take && (i_mode == wvsd_pkg::MODE_START);
    assign w_req.push  = (r_state == S_WRITE);
    assign w_req.run   = (r_state == S_WRITE) && w_full;
    assign w_req.data  = r_quot;

    wvsd_stats #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        r_tol2 <= r_tol * r_tol;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_timeout    <= wvsd_pkg::TIMEOUT_RST;
            r_tol        <= wvsd_pkg::TOLERANCE_RST;
            r_start_time <= '0;
            r_total      <= '0;
            r_active     <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    wvsd_pkg::CFG_TIMEOUT:   r_timeout <= i_cfg_data;
                    wvsd_pkg::CFG_TOLERANCE: r_tol <= i_cfg_data[wvsd_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_res_mean <= '0;
                        r_res_var  <= '0;
                        r_state    <= S_DONE;
                        case (i_mode)
                            wvsd_pkg::MODE_START: begin
                                r_start_time <= i_now_ms;
                                r_total      <= '0;
                                r_active     <= 1'b1;
                                r_res_status <= wvsd_pkg::ST_COLLECTING;
                            end
                            wvsd_pkg::MODE_SAMPLE, wvsd_pkg::MODE_FAIL: begin
                                if (!r_active) begin
                                    r_res_status <= wvsd_pkg::ST_IGNORED;
                                end else if (w_expired) begin
                                    r_active     <= 1'b0;
                                    r_res_status <= wvsd_pkg::ST_TIMEOUT;
                                end else if (i_mode == wvsd_pkg::MODE_FAIL) begin
                                    r_active     <= 1'b0;
                                    r_res_status <= wvsd_pkg::ST_ERROR;
                                end else begin
                                    r_sample <= i_sample_ns;
                                    r_state  <= S_CONV;
                                end
                            end
                            default: begin
                                r_res_status <= wvsd_pkg::ST_IGNORED;
                            end
                        endcase
                    end
                end
                S_CONV: begin
                    r_quot  <= w_uprod[wvsd_pkg::US_SHIFT +: wvsd_pkg::MEAN_W];
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_total <= n_total;
                    if (w_full) begin
                        r_state <= S_STATS;
                    end else begin
                        r_res_status <= wvsd_pkg::ST_COLLECTING;
                        r_state      <= S_DONE;
                    end
                end
                S_STATS: begin
                    if (w_rsp.done) begin
                        r_res_mean <= w_rsp.mean;
                        r_res_var  <= w_rsp.variance;
                        if (w_rsp.variance < r_tol2) begin
                            r_active     <= 1'b0;
                            r_res_status <= wvsd_pkg::ST_STABLE;
                        end else begin
                            r_res_status <= wvsd_pkg::ST_UNSTABLE;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_status  <= r_res_status;
                        r_out_mean    <= r_res_mean;
                        r_out_var     <= r_res_var;
                        r_out_samples <= r_total;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_mean_us      = r_out_mean;
    assign o_variance_out = r_out_var;
    assign o_samples_seen = r_out_samples;

    a_done_in_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> r_state == S_STATS)
        else $error("statistics result outside wait state");

    a_stable_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res_status == wvsd_pkg::ST_STABLE) |-> !r_active)
        else $error("run still active after stable result");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != wvsd_pkg::ST_STABLE
         && o_status != wvsd_pkg::ST_UNSTABLE)
        |-> (o_mean_us == '0 && o_variance_out == '0))
        else $error("statistics fields set without a full window");

    a_full_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == wvsd_pkg::ST_STABLE
         || o_status == wvsd_pkg::ST_UNSTABLE))
        |-> o_samples_seen >= wvsd_pkg::COUNT_W'(WINDOW_SIZE))
        else $error("window result before window filled");

endmodule
